[src/a2l_pkg.sv]
// shared types and constants of the annex-b to length-prefixed nal converter
`timescale 1ns / 1ps
`default_nettype none

package a2l_pkg;

  localparam int DEF_BUF_BYTES = 65536;
  localparam int DEF_NAL_SLOTS = 64;

  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_AUD  = 5'd9;

  // item kind carried in in_tuser
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_END  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  // output sequencer: idle, length bytes 1..3 sent, payload
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_LEN3 = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  // record queue controls
  typedef struct packed {
    logic push;
    logic push_last;
    logic set_last;
    logic pop;
  } rq_ctl_t;

  // one result item before the store byte is merged in
  typedef struct packed {
    logic [7:0] data;
    logic       is_len;
    logic       pend;
    logic       pempty;
    logic       ovf;
    logic       from_store;
  } out_item_t;

endpackage

`default_nettype wire

[src/a2l_byte_store.sv]
// circular nal byte store, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module a2l_byte_store #(
  parameter int BUF_BYTES = a2l_pkg::DEF_BUF_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(BUF_BYTES)-1:0] wr_addr,
  input  wire logic [7:0]                   wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(BUF_BYTES)-1:0] rd_addr,
  output logic      [7:0]                   rd_data
);

  logic [7:0] mem [BUF_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/a2l_rec_queue.sv]
// nal record queue: older records in memory, newest in a hold register
`timescale 1ns / 1ps
`default_nettype none

module a2l_rec_queue #(
  parameter int BUF_BYTES = a2l_pkg::DEF_BUF_BYTES,
  parameter int NAL_SLOTS = a2l_pkg::DEF_NAL_SLOTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire a2l_pkg::rq_ctl_t               ctl,
  input  wire logic [$clog2(BUF_BYTES)-1:0]   push_len,
  output logic      [$clog2(BUF_BYTES)-1:0]   head_len,
  output logic                                head_last,
  output logic      [$clog2(NAL_SLOTS+1)-1:0] count,
  output logic                                full
);

  localparam int LEN_W  = $clog2(BUF_BYTES);
  localparam int REC_W  = LEN_W + 1;
  localparam int SLOT_W = $clog2(NAL_SLOTS);
  localparam int CNT_W  = $clog2(NAL_SLOTS + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NAL_SLOTS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(NAL_SLOTS);
  localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

  logic [REC_W-1:0]  mem [NAL_SLOTS];

  logic [SLOT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              popped_r;
  logic [REC_W-1:0]  hold_r, hold_nxt;
  logic [REC_W-1:0]  headreg_r, headreg_nxt;
  logic [REC_W-1:0]  mem_q_r;
  logic [REC_W-1:0]  view;
  logic [SLOT_W-1:0] head_inc, tail_inc, tail_m1;

  assign head_inc = (head_r == SLOT_LAST) ? '0 : head_r + SLOT_W'(1);
  assign tail_inc = (tail_r == SLOT_LAST) ? '0 : tail_r + SLOT_W'(1);
  assign tail_m1  = (tail_r == '0) ? SLOT_LAST : tail_r - SLOT_W'(1);

  // head record: hold when it is the only one, fresh read just after a pop
  always_comb begin
    if (count_r == ONE_CNT) begin
      view = hold_r;
    end else if (popped_r) begin
      view = mem_q_r;
    end else begin
      view = headreg_r;
    end
  end

  assign head_len  = view[LEN_W-1:0];
  assign head_last = view[LEN_W];
  assign count     = count_r;
  assign full      = (count_r == FULL_CNT);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    hold_nxt    = hold_r;
    headreg_nxt = view;
    if (ctl.push) begin
      hold_nxt  = {ctl.push_last, push_len};
      tail_nxt  = tail_inc;
      count_nxt = count_r + CNT_W'(1);
      if (count_r == ONE_CNT) begin
        headreg_nxt = hold_r;
      end
    end else if (ctl.set_last) begin
      hold_nxt[LEN_W] = 1'b1;
    end
    if (ctl.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      popped_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      popped_r <= ctl.pop;
    end
  end

  // demote the held record into memory when a newer one arrives
  always_ff @(posedge clk) begin
    if (ctl.push && (count_r != '0)) begin
      mem[tail_m1] <= hold_r;
    end
    mem_q_r   <= mem[head_inc];
    hold_r    <= hold_nxt;
    headreg_r <= headreg_nxt;
  end

endmodule

`default_nettype wire

[src/a2l_out_stage.sv]
// result pipeline: store read stage and output register with backpressure
`timescale 1ns / 1ps
`default_nettype none

module a2l_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_v,
  input  wire a2l_pkg::out_item_t item,
  input  wire logic [7:0]         store_data,
  output logic                    take,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata,   // [7:0] out_byte, [8] overflow
  output logic [1:0]              out_tuser,   // [0] is_length_byte, [1] packet_empty
  output logic                    out_tlast
);

  logic               s1_v_r, s1_v_nxt;
  a2l_pkg::out_item_t s1_r;
  logic               out_v_r, out_v_nxt;
  logic               s1_move;
  logic [7:0]         out_byte_r;
  logic               out_len_r, out_end_r, out_empty_r, out_ovf_r;

  assign s1_move = s1_v_r && (!out_v_r || out_tready);
  assign take    = !s1_v_r || s1_move;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (item_v) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_move) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_v) begin
      s1_r <= item;
    end
    if (s1_move) begin
      out_byte_r  <= s1_r.from_store ? store_data : s1_r.data;
      out_len_r   <= s1_r.is_len;
      out_end_r   <= s1_r.pend;
      out_empty_r <= s1_r.pempty;
      out_ovf_r   <= s1_r.ovf;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_ovf_r, out_byte_r};
  assign out_tuser  = {out_empty_r, out_len_r};
  assign out_tlast  = out_end_r;

endmodule

`default_nettype wire

[src/annexb_to_length_prefixed_nal_core.sv]
// top level: annex-b byte stream to 4-byte length-prefixed nal units
// throughput: one item per clock whenever the output side takes results
// path: a tick's result waits in the stage register while the byte store is read,
// then moves into the output register once that register is free or being taken
// reset: synchronous, pointers, counters and flags cleared, memories left as they are
`timescale 1ns / 1ps
`default_nettype none

module annexb_to_length_prefixed_nal_core #(
  parameter int BUF_BYTES = a2l_pkg::DEF_BUF_BYTES,
  parameter int NAL_SLOTS = a2l_pkg::DEF_NAL_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,    // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [7:0] out_byte, [8] overflow
  output logic [1:0]       out_tuser,   // [0] is_length_byte, [1] packet_empty
  output logic             out_tlast    // packet_end
);

  localparam int ADDR_W = $clog2(BUF_BYTES);
  localparam int CNT_W  = $clog2(NAL_SLOTS + 1);
  localparam logic [ADDR_W-1:0] BUF_LAST = ADDR_W'(BUF_BYTES - 1);
  localparam logic [ADDR_W:0]   BUF_SIZE = (ADDR_W + 1)'(BUF_BYTES);

  // handshake and item decode
  logic              in_acc;
  a2l_pkg::cmd_t     cmd;
  logic [7:0]        b;

  // stream side state
  logic [ADDR_W-1:0] wp_r, wp_nxt;          // next free byte in the store
  logic [ADDR_W-1:0] nbp_r, nbp_nxt;        // first byte of the open nal
  logic [ADDR_W-1:0] nal_len_r, nal_len_nxt;
  logic [7:0]        first_r, first_nxt;    // first stored byte of the open nal
  logic [1:0]        zr_r, zr_nxt;          // zero run, saturating
  logic              inside_r, inside_nxt;
  logic              unit_has_r, unit_has_nxt;
  logic              ovf_r, ovf_nxt;

  // output side state
  a2l_pkg::phase_t   phase_r, phase_nxt;
  logic [ADDR_W-1:0] rp_r, rp_nxt;
  logic [ADDR_W-1:0] remain_r, remain_nxt;

  // byte store
  logic              wr_en;
  logic              rd_en;
  logic [7:0]        rd_data;

  // record queue
  a2l_pkg::rq_ctl_t  rq_ctl;
  logic              rq_push, rq_push_last, rq_set_last, rq_pop;
  logic [ADDR_W-1:0] rq_push_len;
  logic [ADDR_W-1:0] head_len;
  logic              head_last;
  logic [CNT_W-1:0]  rq_count;
  logic              rq_full;
  logic              head_ready;

  // close of the open nal
  logic              sc_hit;
  logic [ADDR_W-1:0] wp_inc, rp_inc;
  logic              store_full;
  logic [1:0]        strip, k;
  logic [ADDR_W-1:0] len_kept;
  logic [ADDR_W:0]   wp_diff, wp_wrap;
  logic [ADDR_W-1:0] wp_back;
  logic              is_aud, nal_ok, nal_push, nal_ovf;

  // result item
  logic              item_v;
  a2l_pkg::out_item_t item;
  logic [31:0]       len32;
  logic              stage_take;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = stage_take;
  assign cmd       = a2l_pkg::cmd_t'(in_tuser);
  assign b         = in_tdata;

  // two or more zeros and then 01 is a start code
  assign sc_hit     = (b == a2l_pkg::START_BYTE) && (zr_r >= 2'd2);
  assign wp_inc     = (wp_r == BUF_LAST) ? '0 : wp_r + ADDR_W'(1);
  assign rp_inc     = (rp_r == BUF_LAST) ? '0 : rp_r + ADDR_W'(1);
  // one slot always kept free so a full store is told from an empty one
  assign store_full = (wp_inc == rp_r);

  // trailing zeros of a start code come off the nal, never more than it holds
  assign strip    = (cmd == a2l_pkg::CMD_BYTE) ? zr_r : 2'd0;
  assign k        = (nal_len_r < ADDR_W'(strip)) ? nal_len_r[1:0] : strip;
  assign len_kept = nal_len_r - ADDR_W'(k);
  assign wp_diff  = {1'b0, wp_r} - (ADDR_W + 1)'(k);
  assign wp_wrap  = wp_diff[ADDR_W] ? wp_diff + BUF_SIZE : wp_diff;
  assign wp_back  = wp_wrap[ADDR_W-1:0];

  // empty nals and access unit delimiters are dropped
  assign is_aud   = (first_r[4:0] & a2l_pkg::NAL_TYPE_MASK) == a2l_pkg::NAL_TYPE_AUD;
  assign nal_ok   = (len_kept != '0) && !is_aud;
  assign nal_push = nal_ok && !rq_full;
  assign nal_ovf  = nal_ok && rq_full;

  // stream bytes and end of access unit
  always_comb begin
    wp_nxt       = wp_r;
    nbp_nxt      = nbp_r;
    nal_len_nxt  = nal_len_r;
    first_nxt    = first_r;
    zr_nxt       = zr_r;
    inside_nxt   = inside_r;
    unit_has_nxt = unit_has_r;
    ovf_nxt      = ovf_r;
    wr_en        = 1'b0;
    rq_push      = 1'b0;
    rq_push_last = 1'b0;
    rq_set_last  = 1'b0;
    rq_push_len  = len_kept;
    if (in_acc) begin
      case (cmd)
        a2l_pkg::CMD_BYTE: begin
          if (sc_hit) begin
            if (inside_r) begin
              if (nal_push) begin
                rq_push      = 1'b1;
                unit_has_nxt = 1'b1;
                wp_nxt       = wp_back;
              end else begin
                wp_nxt = nbp_r;
              end
              if (nal_ovf) begin
                ovf_nxt = 1'b1;
              end
            end
            nbp_nxt     = wp_nxt;
            inside_nxt  = 1'b1;
            zr_nxt      = 2'd0;
            nal_len_nxt = '0;
          end else begin
            if (b == 8'h00) begin
              zr_nxt = (zr_r == 2'd3) ? 2'd3 : zr_r + 2'd1;
            end else begin
              zr_nxt = 2'd0;
            end
            if (inside_r) begin
              if (store_full) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_en       = 1'b1;
                wp_nxt      = wp_inc;
                nal_len_nxt = nal_len_r + ADDR_W'(1);
                if (nal_len_r == '0) begin
                  first_nxt = b;
                end
              end
            end
          end
        end
        a2l_pkg::CMD_END: begin
          // close with trailing zeros kept, flag the unit's last record
          if (inside_r) begin
            if (!nal_push) begin
              wp_nxt = nbp_r;
            end
            if (nal_ovf) begin
              ovf_nxt = 1'b1;
            end
            nbp_nxt = wp_nxt;
          end
          if (inside_r && nal_push) begin
            rq_push      = 1'b1;
            rq_push_last = 1'b1;
          end else if (unit_has_r) begin
            rq_set_last = 1'b1;
          end else if (!rq_full) begin
            // empty marker for a unit without nal
            rq_push      = 1'b1;
            rq_push_last = 1'b1;
            rq_push_len  = '0;
          end else begin
            ovf_nxt = 1'b1;
          end
          inside_nxt   = 1'b0;
          zr_nxt       = 2'd0;
          unit_has_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // newest record of an open unit waits until it is known to be last or not
  assign head_ready = (rq_count != '0) && ((rq_count != CNT_W'(1)) || head_last);
  assign len32      = 32'(head_len);

  // output sequencer, next state
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc && (cmd == a2l_pkg::CMD_TICK)) begin
      case (phase_r)
        a2l_pkg::PH_IDLE: begin
          if (head_ready && (head_len != '0)) begin
            phase_nxt = a2l_pkg::PH_LEN1;
          end
        end
        a2l_pkg::PH_LEN1: phase_nxt = a2l_pkg::PH_LEN2;
        a2l_pkg::PH_LEN2: phase_nxt = a2l_pkg::PH_LEN3;
        a2l_pkg::PH_LEN3: phase_nxt = a2l_pkg::PH_PAY;
        a2l_pkg::PH_PAY: begin
          if (remain_r <= ADDR_W'(1)) begin
            phase_nxt = a2l_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = a2l_pkg::PH_IDLE;
      endcase
    end
  end

  // output sequencer, result item and pointer moves
  always_comb begin
    item_v     = 1'b0;
    item       = '0;
    item.ovf   = ovf_r;
    rd_en      = 1'b0;
    rq_pop     = 1'b0;
    rp_nxt     = rp_r;
    remain_nxt = remain_r;
    if (in_acc && (cmd == a2l_pkg::CMD_TICK)) begin
      case (phase_r)
        a2l_pkg::PH_IDLE: begin
          if (head_ready) begin
            item_v = 1'b1;
            if (head_len == '0) begin
              item.pend   = 1'b1;
              item.pempty = 1'b1;
              rq_pop      = 1'b1;
            end else begin
              item.data   = len32[31:24];
              item.is_len = 1'b1;
              remain_nxt  = head_len;
            end
          end
        end
        a2l_pkg::PH_LEN1: begin
          item_v      = 1'b1;
          item.data   = len32[23:16];
          item.is_len = 1'b1;
        end
        a2l_pkg::PH_LEN2: begin
          item_v      = 1'b1;
          item.data   = len32[15:8];
          item.is_len = 1'b1;
        end
        a2l_pkg::PH_LEN3: begin
          item_v      = 1'b1;
          item.data   = len32[7:0];
          item.is_len = 1'b1;
        end
        a2l_pkg::PH_PAY: begin
          // payload byte comes out of the store read in the next stage
          item_v          = 1'b1;
          item.from_store = 1'b1;
          rd_en           = 1'b1;
          rp_nxt          = rp_inc;
          remain_nxt      = (remain_r != '0) ? remain_r - ADDR_W'(1) : '0;
          if (remain_r <= ADDR_W'(1)) begin
            item.pend = head_last;
            rq_pop    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rq_ctl = '{push: rq_push, push_last: rq_push_last,
                    set_last: rq_set_last, pop: rq_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      nbp_r      <= '0;
      nal_len_r  <= '0;
      zr_r       <= 2'd0;
      inside_r   <= 1'b0;
      unit_has_r <= 1'b0;
      ovf_r      <= 1'b0;
      phase_r    <= a2l_pkg::PH_IDLE;
      rp_r       <= '0;
      remain_r   <= '0;
    end else begin
      wp_r       <= wp_nxt;
      nbp_r      <= nbp_nxt;
      nal_len_r  <= nal_len_nxt;
      zr_r       <= zr_nxt;
      inside_r   <= inside_nxt;
      unit_has_r <= unit_has_nxt;
      ovf_r      <= ovf_nxt;
      phase_r    <= phase_nxt;
      rp_r       <= rp_nxt;
      remain_r   <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

  a2l_byte_store #(
    .BUF_BYTES (BUF_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp_r),
    .wr_data (b),
    .rd_en   (rd_en),
    .rd_addr (rp_r),
    .rd_data (rd_data)
  );

  a2l_rec_queue #(
    .BUF_BYTES (BUF_BYTES),
    .NAL_SLOTS (NAL_SLOTS)
  ) u_recq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rq_ctl),
    .push_len  (rq_push_len),
    .head_len  (head_len),
    .head_last (head_last),
    .count     (rq_count),
    .full      (rq_full)
  );

  a2l_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_v     (item_v),
    .item       (item),
    .store_data (rd_data),
    .take       (stage_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
